/* rtl/stable_noise_loss_detector_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef STABLE_NOISE_LOSS_DETECTOR_ASSERT_SVH
`define STABLE_NOISE_LOSS_DETECTOR_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SNLD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("snld assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define SNLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("snld assertion failed");

// Next-cycle implication that also holds across reset.
`define SNLD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("snld assertion failed");

`endif

/* rtl/snld_pkg.sv */
package snld_pkg;

  localparam int LEVEL_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF  = 12;
  localparam int STREAK_BITS     = 9;
  localparam int LOSS_COUNT_BITS = 8;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [STREAK_BITS-1:0] STREAK_MAX = '1;

  typedef enum logic {
    CMD_LEVEL = 1'b0,
    CMD_RESET = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SAMPLES    = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_LOSS_COUNT = 2'd2
  } cfg_reg_t;

  // One item handed to the tracker for evaluation.
  typedef struct packed {
    logic go;
    cmd_t command;
  } step_t;

endpackage

/* rtl/snld_tracker.sv */
module snld_tracker import snld_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  step_t                      step,
  input  logic [LEVEL_BITS-1:0]      level,
  input  logic [COUNT_BITS-1:0]      samples_per_interval,
  input  logic [LEVEL_BITS-1:0]      level_threshold,
  input  logic [LOSS_COUNT_BITS-1:0] intervals_for_loss,
  output logic                       loss_nxt
);

  localparam int SUM_BITS  = LEVEL_BITS + COUNT_BITS;
  localparam int CNT_W     = COUNT_BITS + 1;
  localparam int PROD_BITS = LEVEL_BITS + CNT_W;
  localparam int CMP_BITS  = SUM_BITS + 4;

  logic [SUM_BITS-1:0]    level_sum_r, level_sum_nxt;
  logic [COUNT_BITS-1:0]  sample_count_r, sample_count_nxt;
  logic [SUM_BITS-1:0]    previous_sum_r, previous_sum_nxt;
  logic [STREAK_BITS-1:0] similar_streak_r, similar_streak_nxt;

  logic [SUM_BITS-1:0]    sum_acc;
  logic [CNT_W-1:0]       count_inc;
  logic                   interval_end;
  logic [SUM_BITS-1:0]    sum_hi, sum_lo;
  logic [CMP_BITS-1:0]    hi_x10, lo_x11;
  logic [PROD_BITS-1:0]   thr_prod;
  logic                   above;
  logic                   similar;
  logic [STREAK_BITS-1:0] streak_upd;

  always_comb begin
    sum_acc      = level_sum_r + SUM_BITS'(level);
    count_inc    = {1'b0, sample_count_r} + CNT_W'(1);
    // A zero interval length ends every interval after one sample.
    interval_end = !(count_inc < {1'b0, samples_per_interval});

    if (sum_acc > previous_sum_r) begin
      sum_hi = sum_acc;
      sum_lo = previous_sum_r;
    end else begin
      sum_hi = previous_sum_r;
      sum_lo = sum_acc;
    end
    hi_x10 = (CMP_BITS'(sum_hi) << 3) + (CMP_BITS'(sum_hi) << 1);
    lo_x11 = (CMP_BITS'(sum_lo) << 3) + (CMP_BITS'(sum_lo) << 1) + CMP_BITS'(sum_lo);

    // Average above threshold, tested on sums to avoid a division.
    thr_prod = PROD_BITS'(level_threshold) * PROD_BITS'(count_inc);
    above    = PROD_BITS'(sum_acc) > thr_prod;

    similar = (sum_lo != '0) && (hi_x10 < lo_x11) && above;

    if (!similar) begin
      streak_upd = '0;
    end else if (similar_streak_r == STREAK_MAX) begin
      streak_upd = similar_streak_r;
    end else begin
      streak_upd = similar_streak_r + STREAK_BITS'(1);
    end
  end

  always_comb begin
    level_sum_nxt      = level_sum_r;
    sample_count_nxt   = sample_count_r;
    previous_sum_nxt   = previous_sum_r;
    similar_streak_nxt = similar_streak_r;
    loss_nxt           = 1'b0;
    if (step.go) begin
      if (step.command == CMD_RESET) begin
        level_sum_nxt      = '0;
        sample_count_nxt   = '0;
        similar_streak_nxt = '0;
      end else if (level_threshold != '0) begin
        if (!interval_end) begin
          level_sum_nxt    = sum_acc;
          sample_count_nxt = count_inc[COUNT_BITS-1:0];
        end else begin
          previous_sum_nxt   = sum_acc;
          level_sum_nxt      = '0;
          sample_count_nxt   = '0;
          similar_streak_nxt = streak_upd;
          loss_nxt           = (streak_upd == STREAK_BITS'(intervals_for_loss));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_sum_r      <= '0;
      sample_count_r   <= '0;
      previous_sum_r   <= '0;
      similar_streak_r <= '0;
    end else begin
      level_sum_r      <= level_sum_nxt;
      sample_count_r   <= sample_count_nxt;
      previous_sum_r   <= previous_sum_nxt;
      similar_streak_r <= similar_streak_nxt;
    end
  end

endmodule

/* rtl/stable_noise_loss_detector.sv */
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    in_command, in_level
// out      output     out_valid/out_stall  out_loss_detected
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction is accepted per clock while in_stall is low; each produces exactly one result.
// An input register feeds the interval evaluation (one threshold-by-count multiply and
// the similarity compare), whose result is written into the result register.
// Reset is synchronous and active low; it clears the sums, counters, streak and valid flags.
// A stall on the output backs up into in_stall once both registers hold an item.
// cfg_ready is always high; a write to an unused index is ignored.
module stable_noise_loss_detector import snld_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [LEVEL_BITS-1:0]     in_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_loss_detected,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [COUNT_BITS-1:0]      samples_per_interval_r;
  logic [LEVEL_BITS-1:0]      level_threshold_r;
  logic [LOSS_COUNT_BITS-1:0] intervals_for_loss_r;

  logic                  s1_valid_r;
  cmd_t                  s1_command_r;
  logic [LEVEL_BITS-1:0] s1_level_r;
  logic                  out_valid_r;
  logic                  out_loss_r;

  logic  out_free;
  logic  s1_go;
  logic  in_take;
  logic  loss_nxt;
  step_t step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_per_interval_r <= COUNT_BITS'(1);
      level_threshold_r      <= '0;
      intervals_for_loss_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SAMPLES:    samples_per_interval_r <= cfg_data[COUNT_BITS-1:0];
        REG_THRESHOLD:  level_threshold_r      <= cfg_data[LEVEL_BITS-1:0];
        REG_LOSS_COUNT: intervals_for_loss_r   <= cfg_data[LOSS_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign step.go      = s1_go;
  assign step.command = s1_command_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take || s1_go) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command_r <= cmd_t'(in_command);
      s1_level_r   <= in_level;
    end
  end

  snld_tracker #(
    .LEVEL_BITS(LEVEL_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_tracker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .step                 (step),
    .level                (s1_level_r),
    .samples_per_interval (samples_per_interval_r),
    .level_threshold      (level_threshold_r),
    .intervals_for_loss   (intervals_for_loss_r),
    .loss_nxt             (loss_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_loss_r <= loss_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_loss_detected = out_loss_r;

endmodule

/* rtl/snld_checker.sv */
`include "stable_noise_loss_detector_assert.svh"

module snld_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_loss_detected
);

  logic [1:0] pending_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Transactions taken in whose results have not been delivered yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `SNLD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)
  `SNLD_ASSERT_IMPLY(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall)
  `SNLD_ASSERT_IMPLY(a_pending_bound, clk, rst_n, out_valid, pending_r != 2'd0 && pending_r != 2'd3)
  `SNLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_loss_detected))

endmodule

bind stable_noise_loss_detector snld_checker u_snld_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_loss_detected (out_loss_detected)
);

/* verif/snld_loss_checker.sv */
`timescale 1ns / 1ps
module snld_loss_checker import snld_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_command,
  input  logic [LEVEL_BITS_DEF-1:0] in_level,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_loss_detected,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        mismatches,
  output int                        pending
);

  localparam int LW = LEVEL_BITS_DEF;
  localparam int CW = COUNT_BITS_DEF;
  localparam int SW = LW + CW;

  // Register copies.
  logic [CW-1:0]              interval_len;
  logic [LW-1:0]              min_level;
  logic [LOSS_COUNT_BITS-1:0] loss_streak;

  // Detector state.
  logic [SW-1:0]          acc_sum;
  logic [CW-1:0]          acc_count;
  logic [SW-1:0]          last_sum;
  logic [STREAK_BITS-1:0] streak;

  logic loss_flags_due[$];
  logic due;

  // Two interval sums match when they are nonzero and within ten percent.
  function automatic logic sums_match(logic [SW-1:0] a, logic [SW-1:0] b);
    logic [SW+7:0] hi;
    logic [SW+7:0] lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    return (lo != '0) && (hi * 10 < lo * 11);
  endfunction

  function automatic logic predict_loss(cmd_t cmd, logic [LW-1:0] lvl);
    logic [SW-1:0] nsum;
    logic [CW:0]   ncount;
    logic [31:0]   floor_sum;
    logic          hit;
    if (cmd == CMD_RESET) begin
      acc_sum = '0;
      acc_count = '0;
      streak = '0;
      return 1'b0;
    end
    if (min_level == '0) return 1'b0;
    nsum = acc_sum + {{CW{1'b0}}, lvl};
    ncount = {1'b0, acc_count} + 1'b1;
    if (ncount < {1'b0, interval_len}) begin
      acc_sum = nsum;
      acc_count = ncount[CW-1:0];
      return 1'b0;
    end
    // The average beats the threshold exactly when the sum beats threshold times count.
    floor_sum = min_level * ncount;
    hit = sums_match(nsum, last_sum) && ({{(32-SW){1'b0}}, nsum} > floor_sum);
    last_sum = nsum;
    acc_sum = '0;
    acc_count = '0;
    if (hit) begin
      if (streak != STREAK_MAX) streak = streak + 1'b1;
    end else begin
      streak = '0;
    end
    return streak == {1'b0, loss_streak};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      interval_len = CW'(1);
      min_level = '0;
      loss_streak = '0;
      acc_sum = '0;
      acc_count = '0;
      last_sum = '0;
      streak = '0;
      loss_flags_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLES:    interval_len = cfg_data[CW-1:0];
          REG_THRESHOLD:  min_level = cfg_data[LW-1:0];
          REG_LOSS_COUNT: loss_streak = cfg_data[LOSS_COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (loss_flags_due.size() == 0) begin
          if (mismatches < 10)
            $display("loss flag %0b arrived with no transaction outstanding",
                     out_loss_detected);
          mismatches++;
        end else begin
          due = loss_flags_due.pop_front();
          if (out_loss_detected !== due) begin
            if (mismatches < 10)
              $display("loss flag mismatch: expected %0b, got %0b", due, out_loss_detected);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        loss_flags_due.push_back(predict_loss(cmd_t'(in_command), in_level));
    end
    pending = loss_flags_due.size();
  end

endmodule

/* verif/tb_stable_noise_loss_detector.sv */
`timescale 1ns / 1ps
module tb_stable_noise_loss_detector;
  import snld_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT = 29;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
  localparam logic [LEVEL_BITS_DEF-1:0] LEVEL_MAX = '1;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_command = 1'b0;
  logic [LEVEL_BITS_DEF-1:0] in_level = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_loss_detected;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  logic no_gaps = 1'b0;
  int   cycles = 0;
  int   mismatches;
  int   pending;

  always #5 clk = ~clk;

  stable_noise_loss_detector dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_level(in_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_loss_detected(out_loss_detected),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  snld_loss_checker u_loss_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_level(in_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_loss_detected(out_loss_detected),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[stable_noise_loss_detector] ERROR");
      $finish;
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [LEVEL_BITS_DEF-1:0] lvl);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Unused upper data bits carry random values; the block must ignore them.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    logic [CFG_DATA_BITS-1:0] word;
    word = $urandom;
    case (idx)
      REG_SAMPLES:    word[COUNT_BITS_DEF-1:0] = val[COUNT_BITS_DEF-1:0];
      REG_THRESHOLD:  word[LEVEL_BITS_DEF-1:0] = val[LEVEL_BITS_DEF-1:0];
      REG_LOSS_COUNT: word[LOSS_COUNT_BITS-1:0] = val[LOSS_COUNT_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A level a few percent above base, so that consecutive intervals stay similar.
  function automatic logic [LEVEL_BITS_DEF-1:0] near_level(int unsigned base);
    int unsigned v;
    v = base + $urandom_range(base / 32);
    return (v > 65535) ? LEVEL_MAX : v[LEVEL_BITS_DEF-1:0];
  endfunction

  initial begin
    int unsigned spi;
    int unsigned thr;
    int unsigned loss_at;
    int unsigned base;
    int unsigned pick;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the threshold is zero, so samples must not count.
    send_item(CMD_LEVEL, '0);
    send_item(CMD_LEVEL, LEVEL_MAX);
    send_item(CMD_LEVEL, 16'h5555);
    send_item(CMD_RESET, 16'hAAAA);
    settle();

    // A zero interval length behaves as one sample per interval.
    write_reg(REG_SAMPLES, 0);
    write_reg(REG_THRESHOLD, 1);
    write_reg(REG_LOSS_COUNT, 0);
    write_reg(REG_SPARE, $urandom);
    send_item(CMD_LEVEL, '0);
    send_item(CMD_LEVEL, '0);
    send_item(CMD_LEVEL, 16'd100);
    send_item(CMD_LEVEL, 16'd105);
    send_item(CMD_LEVEL, 16'd105);
    send_item(CMD_LEVEL, 16'h5555);
    send_item(CMD_LEVEL, 16'hAAAA);
    send_item(CMD_RESET, LEVEL_MAX);
    send_item(CMD_LEVEL, LEVEL_MAX);
    settle();

    // Lowering the interval below the count reached ends the interval on the next sample.
    write_reg(REG_SAMPLES, 8);
    write_reg(REG_THRESHOLD, 65535);
    write_reg(REG_LOSS_COUNT, 255);
    repeat (5) send_item(CMD_LEVEL, LEVEL_MAX);
    settle();
    write_reg(REG_SAMPLES, 2);
    repeat (3) send_item(CMD_LEVEL, LEVEL_MAX);
    settle();

    // Long similar run: the streak passes 255 and must keep counting instead of wrapping.
    write_reg(REG_SAMPLES, 1);
    write_reg(REG_THRESHOLD, 1);
    write_reg(REG_LOSS_COUNT, 255);
    base = $urandom_range(1000, 40000);
    no_gaps <= 1'b1;
    for (int i = 0; i < 300; i++) begin
      if (i == 200) no_gaps <= 1'b0;
      send_item(CMD_LEVEL, near_level(base));
    end
    settle();
    write_reg(REG_LOSS_COUNT, 0);
    repeat (40) send_item(CMD_LEVEL, near_level(base));
    settle();

    // Full-scale samples over a longer interval, where the sum only just beats the threshold.
    write_reg(REG_SAMPLES, 40);
    write_reg(REG_THRESHOLD, 65534);
    write_reg(REG_LOSS_COUNT, 1);
    send_item(CMD_RESET, '0);
    repeat (2 * 40) send_item(CMD_LEVEL, LEVEL_MAX);
    settle();

    for (int p = 0; p < 5; p++) begin
      pick = $urandom_range(3);
      spi = ($urandom_range(4) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      case (pick)
        0: thr = 0;
        1: thr = $urandom_range(1, 255);
        2: thr = $urandom_range(256, 65535);
        default: thr = $urandom_range(1, 40000);
      endcase
      loss_at = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(3);
      write_reg(REG_SAMPLES, spi);
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_LOSS_COUNT, loss_at);
      base = (thr == 0 || thr == 65535) ? $urandom_range(65535) : $urandom_range(thr + 1, 65535);
      repeat (40) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_item(CMD_RESET, LEVEL_BITS_DEF'($urandom_range(65535)));
        end else if (pick < 18) begin
          send_item(CMD_LEVEL, LEVEL_BITS_DEF'($urandom_range(65535)));
        end else begin
          send_item(CMD_LEVEL, near_level(base));
        end
      end
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("[stable_noise_loss_detector] OK");
    end else begin
      $display("[stable_noise_loss_detector] ERROR");
    end
    $finish;
  end

endmodule
